@@ src/lvp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes of the point-in-solid visibility block.
package lvp_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned PROD_W     = 49;
  localparam int unsigned PROJ_W     = 51;
  localparam int unsigned PQ_W       = 36;
  localparam int unsigned QP_W       = 52;
  localparam int unsigned OFF_W      = 37;
  localparam int unsigned PERP_W     = 38;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned SUM_W      = 66;
  localparam int unsigned HALF_W     = 46;
  localparam int unsigned POSW_W     = 52;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned RCF_W      = 64;
  localparam int unsigned RC_W       = 48;
  localparam int unsigned FRAC_SH    = 15;
  localparam int unsigned MARGIN_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned N_AXES     = 3;
  localparam int unsigned PIPE_DEPTH = 7;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd66;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SPHERE,
    KIND_CYLINDER,
    KIND_CONE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_AXIS,
    REG_RADIUS,
    REG_HEIGHT,
    REG_MARGIN
  } reg_idx_e;

  typedef struct packed {
    kind_e                kind;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic [COORD_W-1:0]   center_z;
    logic [CFG_DATA_W-1:0] axis;
    logic [COORD_W-1:0]   radius;
    logic [COORD_W-1:0]   height;
    logic [MARGIN_W-1:0]  margin;
  } cfg_t;

endpackage

@@ src/lvp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for point pairs and visibility results.
interface lvp_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   eye_x;
  logic signed [31:0]   eye_y;
  logic signed [31:0]   eye_z;
  logic signed [31:0]   lamp_x;
  logic signed [31:0]   lamp_y;
  logic signed [31:0]   lamp_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, lamp_x, lamp_y, lamp_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, lamp_x, lamp_y, lamp_z,
    output ready
  );
endinterface

interface lvp_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic eye_inside;
  logic lamp_inside;

  modport source (
    output valid, visible, eye_inside, lamp_inside,
    input  ready
  );
  modport sink (
    input  valid, visible, eye_inside, lamp_inside,
    output ready
  );
endinterface

@@ src/lvp_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the point-in-solid block.
module lvp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lvp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lvp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output lvp_pkg::cfg_t                     cfg_o
);

  lvp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{kind: lvp_pkg::KIND_NONE, margin: lvp_pkg::MARGIN_RESET, default: '0};
    end else if (cfg_we_i) begin
      unique case (lvp_pkg::reg_idx_e'(cfg_idx_i))
        lvp_pkg::REG_KIND:     cfg_q.kind     <= lvp_pkg::kind_e'(cfg_data_i[1:0]);
        lvp_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data_i[lvp_pkg::COORD_W-1:0];
        lvp_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[lvp_pkg::COORD_W-1:0];
        lvp_pkg::REG_CENTER_Z: cfg_q.center_z <= cfg_data_i[lvp_pkg::COORD_W-1:0];
        lvp_pkg::REG_AXIS:     cfg_q.axis     <= cfg_data_i;
        lvp_pkg::REG_RADIUS:   cfg_q.radius   <= cfg_data_i[lvp_pkg::COORD_W-1:0];
        lvp_pkg::REG_HEIGHT:   cfg_q.height   <= cfg_data_i[lvp_pkg::COORD_W-1:0];
        lvp_pkg::REG_MARGIN:   cfg_q.margin   <= cfg_data_i[lvp_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/lvp_point.sv @@
`timescale 1ns / 1ps
// Seven-stage datapath that tests one point against the configured solid.
module lvp_point (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  lvp_pkg::cfg_t                  cfg_i,
  input  logic [lvp_pkg::COORD_W-1:0]    pt_x_i,
  input  logic [lvp_pkg::COORD_W-1:0]    pt_y_i,
  input  logic [lvp_pkg::COORD_W-1:0]    pt_z_i,
  output logic                           inside_o
);

  localparam int unsigned N = lvp_pkg::N_AXES;

  logic signed [lvp_pkg::COORD_W-1:0] pt_s   [N];
  logic signed [lvp_pkg::COORD_W-1:0] ctr_s  [N];
  logic signed [lvp_pkg::AXIS_W-1:0]  axis_s [N];

  // stage 1: difference to center
  logic signed [lvp_pkg::DIFF_W-1:0]  d1_d [N];
  logic signed [lvp_pkg::DIFF_W-1:0]  d1_q [N];
  // stage 2: axis products
  logic signed [lvp_pkg::PROD_W-1:0]  prod2_d [N];
  logic signed [lvp_pkg::PROD_W-1:0]  prod2_q [N];
  logic signed [lvp_pkg::DIFF_W-1:0]  d2_q [N];
  // stage 3: projection
  logic signed [lvp_pkg::PROJ_W-1:0]  p3_d;
  logic signed [lvp_pkg::PROJ_W-1:0]  p3_q;
  logic signed [lvp_pkg::DIFF_W-1:0]  d3_q [N];
  // stage 4: axial offsets, height test, cone position
  logic signed [lvp_pkg::PQ_W-1:0]    pq;
  logic [lvp_pkg::PROJ_W-1:0]         absp;
  logic [lvp_pkg::HALF_W-1:0]         half;
  logic signed [lvp_pkg::POSW_W-1:0]  posw;
  logic signed [lvp_pkg::QP_W-1:0]    q4_d [N];
  logic signed [lvp_pkg::QP_W-1:0]    q4_q [N];
  logic signed [lvp_pkg::DIFF_W-1:0]  d4_q [N];
  logic                               outh4_d, outh4_q;
  logic [lvp_pkg::POS_W-1:0]          pos4_d, pos4_q;
  // stage 5: perpendicular magnitudes, cone radius product
  logic signed [lvp_pkg::OFF_W-1:0]   off  [N];
  logic signed [lvp_pkg::PERP_W-1:0]  perp [N];
  logic [lvp_pkg::PERP_W-1:0]         mag  [N];
  logic [lvp_pkg::MAG_W-1:0]          mag5_d [N];
  logic [lvp_pkg::MAG_W-1:0]          mag5_q [N];
  logic [N-1:0]                       sat5_d, sat5_q;
  logic [lvp_pkg::RCF_W-1:0]          rcf5_d, rcf5_q;
  logic                               outh5_q;
  // stage 6: squares and squared radius
  logic [lvp_pkg::SQ_W-1:0]           sq6_d [N];
  logic [lvp_pkg::SQ_W-1:0]           sq6_q [N];
  logic [N-1:0]                       sat6_q;
  logic [lvp_pkg::RC_W-1:0]           rc;
  logic [lvp_pkg::SQ_W-1:0]           r2_6_d, r2_6_q;
  logic                               outh6_q;
  // stage 7: saturated distance and threshold
  logic [lvp_pkg::SUM_W-1:0]          sum7;
  logic [lvp_pkg::COORD_W-1:0]        marg;
  logic [lvp_pkg::SQ_W-1:0]           dist7_d, dist7_q;
  logic [lvp_pkg::SQ_W-1:0]           thr7_d, thr7_q;
  logic                               thr_ok7_d, thr_ok7_q;
  logic                               outh7_q;

  assign pt_s[0]   = $signed(pt_x_i);
  assign pt_s[1]   = $signed(pt_y_i);
  assign pt_s[2]   = $signed(pt_z_i);
  assign ctr_s[0]  = $signed(cfg_i.center_x);
  assign ctr_s[1]  = $signed(cfg_i.center_y);
  assign ctr_s[2]  = $signed(cfg_i.center_z);
  assign axis_s[0] = $signed(cfg_i.axis[15:0]);
  assign axis_s[1] = $signed(cfg_i.axis[31:16]);
  assign axis_s[2] = $signed(cfg_i.axis[47:32]);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      d1_d[i]    = lvp_pkg::DIFF_W'(pt_s[i]) - lvp_pkg::DIFF_W'(ctr_s[i]);
      prod2_d[i] = lvp_pkg::PROD_W'(d1_q[i]) * lvp_pkg::PROD_W'(axis_s[i]);
    end
    p3_d = lvp_pkg::PROJ_W'(prod2_q[0]) + lvp_pkg::PROJ_W'(prod2_q[1])
         + lvp_pkg::PROJ_W'(prod2_q[2]);
  end

  always_comb begin
    pq      = $signed(p3_q[lvp_pkg::PROJ_W-1:lvp_pkg::FRAC_SH]);
    absp    = p3_q[lvp_pkg::PROJ_W-1] ? lvp_pkg::PROJ_W'(-p3_q) : lvp_pkg::PROJ_W'(p3_q);
    half    = {cfg_i.height, 14'b0};
    outh4_d = absp > lvp_pkg::PROJ_W'(half);
    posw    = lvp_pkg::POSW_W'(p3_q) + $signed({6'b0, half});
    pos4_d  = posw[lvp_pkg::POS_W+lvp_pkg::FRAC_SH-1:lvp_pkg::FRAC_SH];
    for (int i = 0; i < N; i++) begin
      q4_d[i] = lvp_pkg::QP_W'(axis_s[i]) * lvp_pkg::QP_W'(pq);
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      off[i] = $signed(q4_q[i][lvp_pkg::QP_W-1:lvp_pkg::FRAC_SH]);
      if (cfg_i.kind == lvp_pkg::KIND_SPHERE) begin
        perp[i] = lvp_pkg::PERP_W'(d4_q[i]);
      end else begin
        perp[i] = lvp_pkg::PERP_W'(d4_q[i]) - lvp_pkg::PERP_W'(off[i]);
      end
      mag[i]    = perp[i][lvp_pkg::PERP_W-1] ? lvp_pkg::PERP_W'(-perp[i])
                                             : lvp_pkg::PERP_W'(perp[i]);
      mag5_d[i] = mag[i][lvp_pkg::MAG_W-1:0];
      sat5_d[i] = |mag[i][lvp_pkg::PERP_W-1:lvp_pkg::MAG_W];
    end
    rcf5_d = lvp_pkg::RCF_W'(pos4_q) * lvp_pkg::RCF_W'(cfg_i.radius);
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sq6_d[i] = lvp_pkg::SQ_W'(mag5_q[i]) * lvp_pkg::SQ_W'(mag5_q[i]);
    end
    rc = rcf5_q[lvp_pkg::RCF_W-1:16];
    if (cfg_i.kind == lvp_pkg::KIND_CONE) begin
      if (|rc[lvp_pkg::RC_W-1:lvp_pkg::MAG_W]) begin
        r2_6_d = '1;
      end else begin
        r2_6_d = lvp_pkg::SQ_W'(rc[lvp_pkg::MAG_W-1:0])
               * lvp_pkg::SQ_W'(rc[lvp_pkg::MAG_W-1:0]);
      end
    end else begin
      r2_6_d = lvp_pkg::SQ_W'(cfg_i.radius) * lvp_pkg::SQ_W'(cfg_i.radius);
    end
  end

  always_comb begin
    sum7      = lvp_pkg::SUM_W'(sq6_q[0]) + lvp_pkg::SUM_W'(sq6_q[1])
              + lvp_pkg::SUM_W'(sq6_q[2]);
    dist7_d   = ((|sat6_q) || (|sum7[lvp_pkg::SUM_W-1:lvp_pkg::SQ_W]))
              ? '1 : sum7[lvp_pkg::SQ_W-1:0];
    marg      = {cfg_i.margin, 16'b0};
    thr_ok7_d = r2_6_q > lvp_pkg::SQ_W'(marg);
    thr7_d    = r2_6_q - lvp_pkg::SQ_W'(marg);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        d1_q[i]    <= d1_d[i];
        prod2_q[i] <= prod2_d[i];
        d2_q[i]    <= d1_q[i];
        d3_q[i]    <= d2_q[i];
        q4_q[i]    <= q4_d[i];
        d4_q[i]    <= d3_q[i];
        mag5_q[i]  <= mag5_d[i];
        sq6_q[i]   <= sq6_d[i];
      end
      p3_q      <= p3_d;
      outh4_q   <= outh4_d;
      pos4_q    <= pos4_d;
      sat5_q    <= sat5_d;
      rcf5_q    <= rcf5_d;
      outh5_q   <= outh4_q;
      sat6_q    <= sat5_q;
      r2_6_q    <= r2_6_d;
      outh6_q   <= outh5_q;
      dist7_q   <= dist7_d;
      thr7_q    <= thr7_d;
      thr_ok7_q <= thr_ok7_d;
      outh7_q   <= outh6_q;
    end
  end

  assign inside_o = (cfg_i.kind != lvp_pkg::KIND_NONE)
                 && ((cfg_i.kind == lvp_pkg::KIND_SPHERE) || !outh7_q)
                 && thr_ok7_q && (dist7_q < thr7_q);

endmodule

@@ src/light_visibility_point_in_solid.sv @@
`timescale 1ns / 1ps
// Top level: tests a camera point and a light point against one solid.
//
// Usage: the in_i channel carries a camera point and a light point, Q16.16.
// The out_o channel returns one item per input item: eye_inside, lamp_inside
// and visible, which is high when both points fall on the same side.
// The solid (none, sphere, cylinder or cone), its center, axis, radius or
// slope, height and margin come through the write port cfg_we_i, cfg_idx_i,
// cfg_data_i; write it only while no item is in flight.
// Each item passes through seven datapath stages per point (difference, axis
// products, projection, axial offsets, perpendicular magnitudes, squares,
// saturated sum), the first loaded at the edge that accepts the item, then
// the output register.
// Throughput: one item per cycle while out_o is not stalled; both points run
// through their own datapath side by side.
// Reset clears all valid bits and loads the register defaults (no solid,
// margin 66). When the receiver stalls with a result waiting, the whole
// pipeline holds and in_i.ready drops until the result is taken.
module light_visibility_point_in_solid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lvp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lvp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lvp_in_if.sink                             in_i,
  lvp_out_if.source                          out_o
);

  localparam int unsigned D = lvp_pkg::PIPE_DEPTH;

  lvp_pkg::cfg_t  cfg;
  logic           en;
  logic [D-1:0]   v_q;
  logic           eye_in, lamp_in;
  logic           out_valid_q;
  logic           eye_q, lamp_q;

  lvp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lvp_point u_eye (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .pt_x_i   (in_i.eye_x),
    .pt_y_i   (in_i.eye_y),
    .pt_z_i   (in_i.eye_z),
    .inside_o (eye_in)
  );

  lvp_point u_lamp (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .pt_x_i   (in_i.lamp_x),
    .pt_y_i   (in_i.lamp_y),
    .pt_z_i   (in_i.lamp_z),
    .inside_o (lamp_in)
  );

  // advance the pipeline unless a result waits at the output
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[D-2:0], in_i.valid};
      out_valid_q <= v_q[D-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye_q  <= eye_in;
      lamp_q <= lamp_in;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.eye_inside  = eye_q;
  assign out_o.lamp_inside = lamp_q;
  assign out_o.visible     = (eye_q == lamp_q);

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during stall");

  a_last_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[D-1]) |=> out_o.valid)
    else $error("last stage item not presented at output");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !v_q[D-1]) |=> !out_o.valid)
    else $error("output valid without an item in the last stage");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");
`endif

endmodule
